### hw/rtl/ahct_pkg.sv
// Shared constants, register codes and types of the associative cache hit tracker.
package ahct_pkg;

  localparam int ENTRIES_DEF   = 16;
  localparam int ADDR_BITS_DEF = 32;
  localparam int IN_ADDR_W     = 32;
  localparam int CNT_W         = 32;
  localparam int CAP_W         = 5;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    REG_POLICY   = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_idx_t;

  typedef enum logic {
    POLICY_LRU  = 1'b0,
    POLICY_FIFO = 1'b1
  } policy_t;

  typedef struct packed {
    policy_t              policy;
    logic [CAP_W-1:0]     capacity;
  } ahct_cfg_t;

endpackage

### hw/rtl/assoc_cache_hit_tracker.sv
// Top level of the associative cache hit tracker with input and result registers.
//
//  Channel   Ports                                   Direction  Handshake
//  input     in_address                              in         in_valid / in_stall
//  result    out_hit, out_access_total, out_hit_total out       out_valid / out_stall
//  config    psel penable pwrite paddr pwdata prdata  in/out     APB, pready tied high
//
// A transaction accepted at a clock edge is held in the input register, and its result
// is written to the result register when the lookup advances. With no stalls one
// transaction is accepted every cycle: the parallel tag compare and one-step shift of
// the entry registers complete while the transaction is in the input register.
// Reset is synchronous and clears the occupancy, the counters and the valid flags.
// A stalled result holds the lookup stage, which then stalls the input.
module assoc_cache_hit_tracker #(
  parameter int ENTRIES   = ahct_pkg::ENTRIES_DEF,
  parameter int ADDR_BITS = ahct_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ahct_pkg::IN_ADDR_W-1:0]   in_address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_hit,
  output logic [ahct_pkg::CNT_W-1:0]       out_access_total,
  output logic [ahct_pkg::CNT_W-1:0]       out_hit_total,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ahct_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ahct_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ahct_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  ahct_pkg::ahct_cfg_t                 cfg;
  logic                                s1_valid_r;
  logic [ahct_pkg::IN_ADDR_W-1:0]      s1_addr_r;
  logic                                out_valid_r;
  logic                                out_hit_r;
  logic [ahct_pkg::CNT_W-1:0]          acc_cnt_r;
  logic [ahct_pkg::CNT_W-1:0]          hit_cnt_r;
  logic                                advance;
  logic                                in_take;
  logic                                hit;

  ahct_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ahct_store #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (advance),
    .addr  (s1_addr_r),
    .cfg   (cfg),
    .hit   (hit)
  );

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_addr_r <= in_address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_cnt_r   <= '0;
      hit_cnt_r   <= '0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
      if (acc_cnt_r != '1) begin
        acc_cnt_r <= acc_cnt_r + ahct_pkg::CNT_W'(1);
      end
      if (hit && (hit_cnt_r != '1)) begin
        hit_cnt_r <= hit_cnt_r + ahct_pkg::CNT_W'(1);
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit_r <= hit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_access_total = acc_cnt_r;
  assign out_hit_total    = hit_cnt_r;

endmodule

### hw/rtl/ahct_cfg.sv
// APB configuration registers: replacement policy and capacity.
module ahct_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ahct_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ahct_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ahct_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output ahct_pkg::ahct_cfg_t              cfg
);

  ahct_pkg::policy_t                 policy_r;
  logic [ahct_pkg::CAP_W-1:0]        capacity_r;
  ahct_pkg::reg_idx_t                reg_idx;
  logic                              wr_en;

  assign reg_idx = ahct_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r   <= ahct_pkg::POLICY_LRU;
      capacity_r <= ahct_pkg::CAP_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        ahct_pkg::REG_POLICY:   policy_r   <= ahct_pkg::policy_t'(pwdata[0]);
        ahct_pkg::REG_CAPACITY: capacity_r <= pwdata[ahct_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      ahct_pkg::REG_POLICY:   prdata[0] = policy_r;
      ahct_pkg::REG_CAPACITY: prdata[ahct_pkg::CAP_W-1:0] = capacity_r;
      default: ;
    endcase
  end

  assign cfg.policy   = policy_r;
  assign cfg.capacity = capacity_r;

endmodule

### hw/rtl/ahct_store.sv
// Entry array kept newest first, with parallel compare and one-step reorder.
module ahct_store #(
  parameter int ENTRIES   = ahct_pkg::ENTRIES_DEF,
  parameter int ADDR_BITS = ahct_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             go,
  input  logic [ahct_pkg::IN_ADDR_W-1:0]   addr,
  input  ahct_pkg::ahct_cfg_t              cfg,
  output logic                             hit
);

  localparam int KEY_W = (ADDR_BITS < ahct_pkg::IN_ADDR_W) ? ADDR_BITS : ahct_pkg::IN_ADDR_W;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > ahct_pkg::CAP_W) ? OCC_W : ahct_pkg::CAP_W;
  localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

  logic [KEY_W-1:0]   entry_r [ENTRIES];
  logic [OCC_W-1:0]   occ_r;
  logic [OCC_W-1:0]   occ_nxt;
  logic [KEY_W-1:0]   key;
  logic [CMP_W-1:0]   cap_ext;
  logic [OCC_W-1:0]   cap_eff;
  logic               cap_nz;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] ge;
  logic [ENTRIES-1:0] shift_en;
  logic               lru;

  assign key     = addr[KEY_W-1:0];
  assign cap_ext = CMP_W'(cfg.capacity);
  assign cap_eff = (cap_ext > ENTRIES_C) ? OCC_W'(ENTRIES) : cap_ext[OCC_W-1:0];
  assign cap_nz  = (cap_eff != '0);
  assign lru     = (cfg.policy == ahct_pkg::POLICY_LRU);
  assign hit     = |match;

  genvar i;
  generate
    for (i = 0; i < ENTRIES; i++) begin : g_slot
      assign match[i]    = cap_nz && (OCC_W'(i) < occ_r) && (entry_r[i] == key);
      assign ge[i]       = |match[ENTRIES-1:i];
      assign shift_en[i] = !hit || (lru && ge[i]);

      if (i == 0) begin : g_head
        always_ff @(posedge clk) begin
          if (go && cap_nz && shift_en[i]) begin
            entry_r[i] <= key;
          end
        end
      end else begin : g_body
        always_ff @(posedge clk) begin
          if (go && cap_nz && shift_en[i]) begin
            entry_r[i] <= entry_r[i-1];
          end
        end
      end
    end
  endgenerate

  always_comb begin
    occ_nxt = occ_r;
    if (!cap_nz) begin
      occ_nxt = '0;
    end else if (!hit) begin
      occ_nxt = (occ_r >= cap_eff) ? cap_eff : occ_r + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (go) begin
      occ_r <= occ_nxt;
    end
  end

endmodule
